FILE: rtl/lsi3_pkg.sv
package lsi3_pkg;

    // Tolerance register width and its value after reset
    localparam int TOL_W = 17;
    localparam logic [TOL_W-1:0] TOL_RESET = 17'd1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_HIT         = 2'd0,
        ST_PARALLEL    = 2'd1,
        ST_NONCOPLANAR = 2'd2,
        ST_OUTSIDE     = 2'd3
    } t_status;

    // Per-query classification from the cross-product front end
    typedef struct packed {
        logic [2:0] usable;
        logic       parallel;
    } t_flags;

endpackage

FILE: rtl/line_segment_intersect_3d_unit.sv
// Channel   Dir  Payload                                        Beat taken when
// s_axis    in   tdata: origin xyz, dir xyz, start xyz, end xyz  tvalid && tready
// m_axis    out  tdata: hit xyz; tuser: status                   tvalid && tready
// tol cfg   in   i_tol_wdata: tolerance (unsigned, FRAC_BITS)    i_tol_we
//
// One query per cycle while m_axis does not stall; t comes from the
// bit-per-stage restoring dividers. Synchronous active-low reset clears
// all valid bits and sets tolerance to 1. A stall on m_axis freezes every
// stage together; s_axis_tready is low only while a finished beat waits
// on m_axis.
module line_segment_intersect_3d_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int IDW = ((12 * COORD_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [IDW-1:0]              s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hit_x, hit_y, hit_z
    output logic [ODW-1:0]              m_axis_tdata,
    // status
    output logic [1:0]                  m_axis_tuser,
    input  logic                        i_tol_we,
    input  logic [lsi3_pkg::TOL_W-1:0]  i_tol_wdata
);
    import lsi3_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int FW = FRAC_BITS;
    localparam int AW = CW + 1;
    localparam int MW = 2 * CW + 1;
    localparam int NW = MW + FW;
    localparam int FLW = $bits(t_flags);
    localparam int SW = 3 * CW + 3 * AW + TOL_W + FLW;

    logic                 en;
    logic [TOL_W-1:0]     r_tol;

    logic [2:0][CW-1:0]   in_org;
    logic [2:0][CW-1:0]   in_dir;
    logic [2:0][CW-1:0]   in_start;
    logic [2:0][CW-1:0]   in_end;

    logic                 f_valid;
    logic [2:0][NW-1:0]   f_num;
    logic [2:0][MW-1:0]   f_den;
    logic [2:0]           f_neg;
    logic [2:0][CW-1:0]   f_start;
    logic [2:0][AW-1:0]   f_seg;
    logic [TOL_W-1:0]     f_tol;
    t_flags               f_flags;

    logic                 d_valid;
    logic [2:0][NW:0]     d_quo;
    logic [SW-1:0]        d_side;

    t_status              b_status;
    logic [2:0][CW-1:0]   b_hit;

    // Whole pipeline moves unless a finished beat is held at the output
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_tol_we) begin
            r_tol <= i_tol_wdata;
        end
    end

    // Split the input beat into coordinates
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_org[k]   = s_axis_tdata[k*CW +: CW];
            in_dir[k]   = s_axis_tdata[(3+k)*CW +: CW];
            in_start[k] = s_axis_tdata[(6+k)*CW +: CW];
            in_end[k]   = s_axis_tdata[(9+k)*CW +: CW];
        end
    end

    lsi3_front #(.CW(CW), .FW(FW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_org   (in_org),
        .i_dir   (in_dir),
        .i_start (in_start),
        .i_end   (in_end),
        .i_tol   (r_tol),
        .o_valid (f_valid),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_neg   (f_neg),
        .o_start (f_start),
        .o_seg   (f_seg),
        .o_tol   (f_tol),
        .o_flags (f_flags)
    );

    lsi3_div #(.NW(NW), .DW(MW), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_neg   (f_neg),
        .i_side  ({f_flags, f_tol, f_seg, f_start}),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    lsi3_back #(.CW(CW), .FW(FW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d_valid),
        .i_quo    (d_quo),
        .i_start  (d_side[3*CW-1:0]),
        .i_seg    (d_side[3*CW +: 3*AW]),
        .i_tol    (d_side[3*CW+3*AW +: TOL_W]),
        .i_flags  (t_flags'(d_side[SW-1 -: FLW])),
        .o_valid  (m_axis_tvalid),
        .o_status (b_status),
        .o_hit    (b_hit)
    );

    assign m_axis_tdata = ODW'(b_hit);
    assign m_axis_tuser = b_status;

endmodule

FILE: rtl/lsi3_front.sv
module lsi3_front #(
    parameter int CW = 32,
    parameter int FW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [2:0][CW-1:0]           i_org,
    input  logic [2:0][CW-1:0]           i_dir,
    input  logic [2:0][CW-1:0]           i_start,
    input  logic [2:0][CW-1:0]           i_end,
    input  logic [lsi3_pkg::TOL_W-1:0]   i_tol,
    output logic                         o_valid,
    output logic [2:0][2*CW+FW:0]        o_num,
    output logic [2:0][2*CW:0]           o_den,
    output logic [2:0]                   o_neg,
    output logic [2:0][CW-1:0]           o_start,
    output logic [2:0][CW:0]             o_seg,
    output logic [lsi3_pkg::TOL_W-1:0]   o_tol,
    output lsi3_pkg::t_flags             o_flags
);
    import lsi3_pkg::*;

    localparam int AW = CW + 1;
    localparam int PW = AW + CW;
    localparam int XW = 2 * CW + 2;
    localparam int MW = 2 * CW + 1;
    localparam int NW = MW + FW;
    localparam int KW = TOL_W + FW;
    localparam int EW = MW + KW;
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    logic [5:0]               r_v;
    logic [2:0][CW-1:0]       r_p   [6];
    logic [2:0][AW-1:0]       r_b   [6];
    logic [TOL_W-1:0]         r_tol [6];

    logic signed [AW-1:0]     r_a  [3];
    logic [2:0][CW-1:0]       r_d;
    logic signed [PW-1:0]     r_ap [3];
    logic signed [PW-1:0]     r_am [3];
    logic signed [PW-1:0]     r_bp [3];
    logic signed [PW-1:0]     r_bm [3];
    logic signed [XW-1:0]     r_av [3];
    logic signed [XW-1:0]     r_bv [3];

    logic [2:0][NW-1:0]       r_num [3];
    logic [2:0][MW-1:0]       r_den [3];
    logic [2:0]               r_neg [3];
    logic [2:0]               r_use [2];
    logic [2:0]               r_big [2];
    logic [KW-1:0]            r_clip [3];
    logic [2*KW-1:0]          r_sq   [3];
    logic [2*TOL_W-1:0]       r_tolsq;
    t_flags                   r_flags;

    logic [2:0][AW-1:0]       n_b;
    logic [XW-1:0]            n_bvabs [3];
    logic [XW-1:0]            n_avabs [3];
    logic [EW-1:0]            n_mag   [3];
    logic [EW-1:0]            n_thr;
    logic [2:0]               n_use;
    logic [2:0]               n_big;
    logic [2*KW+1:0]          n_sum;
    logic [2*KW+1:0]          n_thrsq;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Segment direction B = Q - P
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_b[k] = AW'($signed(i_end[k])) - AW'($signed(i_start[k]));
        end
    end

    // Carry start point, segment vector and tolerance down the stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]   <= i_start;
            r_b[0]   <= n_b;
            r_tol[0] <= i_tol;
            for (int s = 1; s < 6; s++) begin
                r_p[s]   <= r_p[s-1];
                r_b[s]   <= r_b[s-1];
                r_tol[s] <= r_tol[s-1];
            end
        end
    end

    // Stage 1: A = P - R, hold V
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= AW'($signed(i_start[k])) - AW'($signed(i_org[k]));
            end
            r_d <= i_dir;
        end
    end

    // Stage 2: cross-product partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ap[k] <= PW'(r_a[NXT[k]]) * PW'($signed(r_d[PRV[k]]));
                r_am[k] <= PW'(r_a[PRV[k]]) * PW'($signed(r_d[NXT[k]]));
                r_bp[k] <= PW'($signed(r_b[0][NXT[k]])) * PW'($signed(r_d[PRV[k]]));
                r_bm[k] <= PW'($signed(r_b[0][PRV[k]])) * PW'($signed(r_d[NXT[k]]));
            end
        end
    end

    // Stage 3: AV = A x V, BV = B x V
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_av[k] <= XW'(r_ap[k]) - XW'(r_am[k]);
                r_bv[k] <= XW'(r_bp[k]) - XW'(r_bm[k]);
            end
        end
    end

    // Magnitudes, usable components, clipped magnitude for the norm test
    always_comb begin
        n_thr = EW'(r_tol[2]) << FW;
        for (int k = 0; k < 3; k++) begin
            n_bvabs[k] = r_bv[k][XW-1] ? XW'(-r_bv[k]) : XW'(r_bv[k]);
            n_avabs[k] = r_av[k][XW-1] ? XW'(-r_av[k]) : XW'(r_av[k]);
            n_mag[k]   = EW'(n_bvabs[k][MW-1:0]);
            n_use[k]   = (|r_bv[k]) && (n_mag[k] >= n_thr);
            n_big[k]   = |(n_mag[k] >> KW);
        end
    end

    // Stage 4: divider operands, quotient sign of -AV / BV
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_num[0][k] <= {n_avabs[k][MW-1:0], {FW{1'b0}}};
                r_den[0][k] <= n_bvabs[k][MW-1:0];
                r_neg[0][k] <= (!r_av[k][XW-1] && (|r_av[k])) != r_bv[k][XW-1];
                r_clip[k]   <= n_mag[k][KW-1:0];
            end
            r_use[0] <= n_use;
            r_big[0] <= n_big;
        end
    end

    // Stage 5: squares of the clipped magnitudes and of the tolerance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (2*KW)'(r_clip[k]) * (2*KW)'(r_clip[k]);
            end
            r_tolsq  <= (2*TOL_W)'(r_tol[3]) * (2*TOL_W)'(r_tol[3]);
            r_num[1] <= r_num[0];
            r_den[1] <= r_den[0];
            r_neg[1] <= r_neg[0];
            r_use[1] <= r_use[0];
            r_big[1] <= r_big[0];
        end
    end

    // Norm of BV against squared threshold; any clipped lane is far above it
    always_comb begin
        n_sum   = (2*KW+2)'(r_sq[0]) + (2*KW+2)'(r_sq[1]) + (2*KW+2)'(r_sq[2]);
        n_thrsq = (2*KW+2)'(r_tolsq) << (2*FW);
    end

    // Stage 6: parallel flag
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[2]         <= r_num[1];
            r_den[2]         <= r_den[1];
            r_neg[2]         <= r_neg[1];
            r_flags.usable   <= r_use[1];
            r_flags.parallel <= ((~|r_big[1]) && (n_sum < n_thrsq)) || (~|r_use[1]);
        end
    end

    assign o_valid = r_v[5];
    assign o_num   = r_num[2];
    assign o_den   = r_den[2];
    assign o_neg   = r_neg[2];
    assign o_start = r_p[5];
    assign o_seg   = r_b[5];
    assign o_tol   = r_tol[5];
    assign o_flags = r_flags;

endmodule

FILE: rtl/lsi3_div.sv
module lsi3_div #(
    parameter int NW = 81,
    parameter int DW = 65,
    parameter int SW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][NW-1:0]    i_num,
    input  logic [2:0][DW-1:0]    i_den,
    input  logic [2:0]            i_neg,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [2:0][NW:0]      o_quo,
    output logic [SW-1:0]         o_side
);

    logic [2:0][NW-1:0]  r_num  [NW];
    logic [2:0][DW-1:0]  r_rem  [NW];
    logic [2:0][DW-1:0]  r_den  [NW];
    logic [2:0]          r_neg  [NW];
    logic [SW-1:0]       r_side [NW];
    logic                r_v    [NW];

    logic [2:0][NW:0]    r_quo;
    logic [SW-1:0]       r_oside;
    logic                r_ov;

    // One restoring step per stage, one quotient bit per lane
    for (genvar g = 0; g < NW; g++) begin : g_step
        logic [2:0][NW-1:0] s_num;
        logic [2:0][DW-1:0] s_rem;
        logic [2:0][DW-1:0] s_den;
        logic [2:0]         s_neg;
        logic [SW-1:0]      s_side;
        logic               s_v;
        logic [DW:0]        n_trial [3];
        logic [DW:0]        n_diff  [3];
        logic [2:0][NW-1:0] n_num;
        logic [2:0][DW-1:0] n_rem;

        if (g == 0) begin : g_src_in
            assign s_num  = i_num;
            assign s_rem  = '0;
            assign s_den  = i_den;
            assign s_neg  = i_neg;
            assign s_side = i_side;
            assign s_v    = i_valid;
        end else begin : g_src_reg
            assign s_num  = r_num[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_den  = r_den[g-1];
            assign s_neg  = r_neg[g-1];
            assign s_side = r_side[g-1];
            assign s_v    = r_v[g-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                n_trial[k] = {s_rem[k], s_num[k][NW-1]};
                n_diff[k]  = n_trial[k] - {1'b0, s_den[k]};
                n_rem[k]   = n_diff[k][DW] ? n_trial[k][DW-1:0] : n_diff[k][DW-1:0];
                n_num[k]   = {s_num[k][NW-2:0], ~n_diff[k][DW]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g]  <= n_num;
                r_rem[g]  <= n_rem;
                r_den[g]  <= s_den;
                r_neg[g]  <= s_neg;
                r_side[g] <= s_side;
            end
        end
    end

    // Apply the quotient sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_quo[k] <= r_neg[NW-1][k] ? (NW+1)'(-{1'b0, r_num[NW-1][k]})
                                           : {1'b0, r_num[NW-1][k]};
            end
            r_oside <= r_side[NW-1];
        end
    end

    assign o_valid = r_ov;
    assign o_quo   = r_quo;
    assign o_side  = r_oside;

endmodule

FILE: rtl/lsi3_back.sv
module lsi3_back #(
    parameter int CW = 32,
    parameter int FW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [2:0][2*CW+FW+1:0]      i_quo,
    input  logic [2:0][CW-1:0]           i_start,
    input  logic [2:0][CW:0]             i_seg,
    input  logic [lsi3_pkg::TOL_W-1:0]   i_tol,
    input  lsi3_pkg::t_flags             i_flags,
    output logic                         o_valid,
    output lsi3_pkg::t_status            o_status,
    output logic [2:0][CW-1:0]           o_hit
);
    import lsi3_pkg::*;

    localparam int AW  = CW + 1;
    localparam int QW  = 2 * CW + FW + 2;
    localparam int PRW = AW + FW + 2;
    localparam int SUW = CW + 3;
    localparam logic signed [QW:0]     ONE  = (QW+1)'(1) << FW;
    localparam logic signed [PRW-1:0]  BIAS = PRW'((64'd1 << FW) - 64'd1);
    localparam logic signed [SUW-1:0]  HI   = {4'b0000, {(CW-1){1'b1}}};
    localparam logic signed [SUW-1:0]  LO   = {4'b1111, {(CW-1){1'b0}}};

    logic [4:0]               r_v;

    logic [1:0]               n_first;
    logic signed [QW:0]       n_t;

    logic signed [QW:0]       r1_t;
    logic signed [QW:0]       r1_d [3];
    logic signed [QW:0]       r1_om;
    logic [1:0]               r1_first;
    t_flags                   r1_flags;
    logic [TOL_W-1:0]         r1_tol;
    logic [2:0][CW-1:0]       r1_p;
    logic [2:0][AW-1:0]       r1_b;

    logic signed [QW:0]       n_tol;
    logic                     n_nc;
    logic                     n_out;
    t_status                  n_status;

    t_status                  r2_status;
    logic [FW:0]              r2_tq;
    logic [2:0][CW-1:0]       r2_p;
    logic [2:0][AW-1:0]       r2_b;

    t_status                  r3_status;
    logic signed [PRW-1:0]    r3_prod [3];
    logic [2:0][CW-1:0]       r3_p;

    logic signed [PRW-1:0]    n_adj [3];

    t_status                  r4_status;
    logic signed [SUW-1:0]    r4_sum [3];

    t_status                  r5_status;
    logic [2:0][CW-1:0]       r5_hit;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Pick t from the first usable component
    always_comb begin
        if (i_flags.usable[0]) begin
            n_first = 2'd0;
        end else if (i_flags.usable[1]) begin
            n_first = 2'd1;
        end else begin
            n_first = 2'd2;
        end
        n_t = (QW+1)'($signed(i_quo[n_first]));
    end

    // Stage 1: differences of each quotient from t, and 1 - t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t <= n_t;
            for (int k = 0; k < 3; k++) begin
                r1_d[k] <= (QW+1)'($signed(i_quo[k])) - n_t;
            end
            r1_om    <= ONE - n_t;
            r1_first <= n_first;
            r1_flags <= i_flags;
            r1_tol   <= i_tol;
            r1_p     <= i_start;
            r1_b     <= i_seg;
        end
    end

    // Classify: parallel, not coplanar, outside, hit
    always_comb begin
        n_tol = (QW+1)'(r1_tol);
        n_nc  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r1_flags.usable[k] && (2'(k) > r1_first)
                && ((r1_d[k] >= n_tol) || (r1_d[k] <= -n_tol))) begin
                n_nc = 1'b1;
            end
        end
        n_out = (r1_t < n_tol) || (r1_om < n_tol);
        if (r1_flags.parallel) begin
            n_status = ST_PARALLEL;
        end else if (n_nc) begin
            n_status = ST_NONCOPLANAR;
        end else if (n_out) begin
            n_status = ST_OUTSIDE;
        end else begin
            n_status = ST_HIT;
        end
    end

    // Stage 2: status; on a hit t lies in [0, 1] and fits FW+1 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_status <= n_status;
            r2_tq     <= r1_t[FW:0];
            r2_p      <= r1_p;
            r2_b      <= r1_b;
        end
    end

    // Stage 3: B * t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_prod[k] <= PRW'($signed(r2_b[k])) * PRW'($signed({1'b0, r2_tq}));
            end
            r3_status <= r2_status;
            r3_p      <= r2_p;
        end
    end

    // Round the scaled product toward zero before the shift
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_adj[k] = r3_prod[k][PRW-1] ? r3_prod[k] + BIAS : r3_prod[k];
        end
    end

    // Stage 4: S = P + B*t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_sum[k] <= $signed(n_adj[k][PRW-1:FW]) + SUW'($signed(r3_p[k]));
            end
            r4_status <= r3_status;
        end
    end

    // Stage 5: saturate, zero unless hit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (r4_status != ST_HIT) begin
                    r5_hit[k] <= '0;
                end else if (r4_sum[k] > HI) begin
                    r5_hit[k] <= HI[CW-1:0];
                end else if (r4_sum[k] < LO) begin
                    r5_hit[k] <= LO[CW-1:0];
                end else begin
                    r5_hit[k] <= r4_sum[k][CW-1:0];
                end
            end
            r5_status <= r4_status;
        end
    end

    assign o_valid  = r_v[4];
    assign o_status = r5_status;
    assign o_hit    = r5_hit;

endmodule

FILE: dv/lsi3_checker.sv
// Watch both streams, predict each query's result and compare it in order
module lsi3_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [383:0]               i_s_tdata,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [95:0]                i_m_tdata,
    input  logic [1:0]                 i_m_tuser,
    input  logic                       i_tol_we,
    input  logic [lsi3_pkg::TOL_W-1:0] i_tol_wdata,
    output int                         o_mismatches,
    output int                         o_outstanding
);
    import lsi3_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] hz;
        logic [31:0] hy;
        logic [31:0] hx;
    } isect_t;

    isect_t          pending_hits[$];
    logic [TOL_W-1:0] tol_shadow;

    // Exact wide-integer model of one line-versus-segment query
    function automatic isect_t intersect_query(input logic [383:0] d,
                                               input logic [TOL_W-1:0] tol_raw);
        wide_t  r[3], v[3], p[3], b[3], a[3], av[3], bv[3];
        wide_t  one, tol, thr, norm, t, s, diff, mag, x, hi, lo;
        isect_t res;
        int     k, u, w, first;
        for (k = 0; k < 3; k++) begin
            r[k] = $signed(d[32*k +: 32]);
            v[k] = $signed(d[32*(3+k) +: 32]);
            p[k] = $signed(d[32*(6+k) +: 32]);
            x    = $signed(d[32*(9+k) +: 32]);
            a[k] = p[k] - r[k];
            b[k] = x - p[k];
        end
        for (k = 0; k < 3; k++) begin
            u = (k + 1) % 3;
            w = (k + 2) % 3;
            av[k] = a[u] * v[w] - a[w] * v[u];
            bv[k] = b[u] * v[w] - b[w] * v[u];
        end
        one  = 65536;
        tol  = tol_raw;
        thr  = tol * one;
        res  = '0;
        res.status = ST_PARALLEL;
        norm = bv[0] * bv[0] + bv[1] * bv[1] + bv[2] * bv[2];
        if (norm < thr * thr) return res;
        // first component of BV that is nonzero and above the threshold
        first = -1;
        for (k = 0; k < 3; k++) begin
            mag = (bv[k] < 0) ? -bv[k] : bv[k];
            if (first < 0 && bv[k] != 0 && mag >= thr) first = k;
        end
        if (first < 0) return res;
        t = (-av[first] * one) / bv[first];
        for (k = first + 1; k < 3; k++) begin
            mag = (bv[k] < 0) ? -bv[k] : bv[k];
            if (bv[k] != 0 && mag >= thr) begin
                s    = (-av[k] * one) / bv[k];
                diff = (s > t) ? s - t : t - s;
                if (diff >= tol) begin
                    res.status = ST_NONCOPLANAR;
                    return res;
                end
            end
        end
        if (t < tol || one - t < tol) begin
            res.status = ST_OUTSIDE;
            return res;
        end
        // hit point, truncated toward zero and clamped to 32 bits
        hi = 2147483647;
        lo = -hi - 1;
        res.status = ST_HIT;
        for (k = 0; k < 3; k++) begin
            x = p[k] + (b[k] * t) / one;
            if (x > hi) x = hi;
            if (x < lo) x = lo;
            if (k == 0) res.hx = x[31:0];
            else if (k == 1) res.hy = x[31:0];
            else res.hz = x[31:0];
        end
        return res;
    endfunction

    assign o_outstanding = pending_hits.size();

    // Track tolerance, queue predictions on input beats, check output beats
    always @(posedge i_clk) begin
        isect_t want, got;
        if (!i_rst_n) begin
            tol_shadow   = TOL_RESET;
            o_mismatches = 0;
        end else begin
            if (i_tol_we) tol_shadow = i_tol_wdata;
            if (i_s_tvalid && i_s_tready)
                pending_hits = {pending_hits, intersect_query(i_s_tdata, tol_shadow)};
            if (i_m_tvalid && i_m_tready) begin
                got = {t_status'(i_m_tuser), i_m_tdata};
                if (pending_hits.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected result beat: status %0d hit %h",
                                 i_m_tuser, i_m_tdata);
                end else begin
                    want = pending_hits.pop_front();
                    if (want.status != got.status || want.hx != got.hx ||
                        want.hy != got.hy || want.hz != got.hz) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("mismatch: status %0d/%0d x %h/%h y %h/%h z %h/%h",
                                     want.status, got.status, want.hx, got.hx,
                                     want.hy, got.hy, want.hz, got.hz);
                    end
                end
            end
        end
    end
endmodule

FILE: dv/tb_line_segment_intersect_3d_unit.sv
module tb_line_segment_intersect_3d_unit;
    import lsi3_pkg::*;

    localparam int SETTLE = 110;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [383:0]      s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [95:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              i_tol_we = 1'b0;
    logic [TOL_W-1:0]  i_tol_wdata = '0;
    int                mismatches, outstanding;
    bit                gaps_on = 1'b1;
    bit                squeeze_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    line_segment_intersect_3d_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_tol_we(i_tol_we), .i_tol_wdata(i_tol_wdata)
    );

    lsi3_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .i_tol_we(i_tol_we), .i_tol_wdata(i_tol_wdata),
        .o_mismatches(mismatches), .o_outstanding(outstanding)
    );

    initial begin
        #50_000_000;
        $display("tb_line_segment_intersect_3d_unit failed");
        $finish;
    end

    // Drain side: random back-pressure plus one long hold-off on request
    initial begin
        bit squeeze_done;
        forever begin
            @(posedge i_clk);
            if (squeeze_req && !squeeze_done) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                squeeze_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 15) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one query and hold it until taken, then maybe leave a gap
    task automatic send_query(input logic signed [31:0] f[12]);
        for (int k = 0; k < 12; k++) s_axis_tdata[32*k +: 32] <= f[k];
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] val);
        i_tol_we    <= 1'b1;
        i_tol_wdata <= val;
        @(posedge i_clk);
        i_tol_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Query in whole units: R, V, P, Q as x,y,z triples scaled by 2^16
    task automatic send_units(input int rx, ry, rz, vx, vy, vz,
                              input int px, py, pz, qx, qy, qz);
        logic signed [31:0] f[12];
        f = '{rx <<< 16, ry <<< 16, rz <<< 16, vx <<< 16, vy <<< 16, vz <<< 16,
              px <<< 16, py <<< 16, pz <<< 16, qx <<< 16, qy <<< 16, qz <<< 16};
        send_query(f);
    endtask

    // Mostly lines aimed through a point of the segment, then noise
    task automatic send_random();
        logic signed [31:0] f[12];
        logic signed [31:0] p[3], b[3], sp[3];
        int kind, frac, scale, span;
        kind = $urandom_range(0, 99);
        span = $urandom_range(4, 20);
        if (kind < 25) begin
            for (int k = 0; k < 12; k++) begin
                f[k] = $urandom;
                if ($urandom_range(0, 1)) f[k] = f[k] >>> $urandom_range(0, 31);
            end
        end else begin
            frac  = $urandom_range(0, 8);
            scale = $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
            for (int k = 0; k < 3; k++) begin
                p[k]  = $signed($urandom) >>> (31 - span);
                b[k]  = ($signed($urandom) >>> (31 - span)) & ~32'sd7;
                sp[k] = p[k] + (b[k] / 8) * frac;
                f[k]     = $signed($urandom) >>> (31 - span);
                f[3 + k] = (sp[k] - f[k]) * scale;
                f[6 + k] = p[k];
                f[9 + k] = p[k] + b[k];
            end
            if (kind < 35) begin
                // direction along the segment
                for (int k = 0; k < 3; k++) f[3 + k] = b[k] * scale;
            end else if (kind < 45) begin
                f[$urandom_range(0, 2)] += $urandom_range(1, 1 << 18);
            end
        end
        send_query(f);
    endtask

    initial begin
        logic signed [31:0] f[12];
        logic [TOL_W-1:0] tol_plan[5];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clean hit, both ends, degenerate and extreme inputs
        send_units(1, 1, 0, 0, -1, 0, 0, 0, 0, 2, 0, 0);
        send_units(0, 1, 0, 0, -1, 0, 0, 0, 0, 2, 0, 0);
        send_units(2, 1, 0, 0, -1, 0, 0, 0, 0, 2, 0, 0);
        send_units(5, 3, 0, 0, -1, 0, 0, 0, 0, 2, 0, 0);
        send_units(1, 1, 3, 0, -1, -1, 0, 0, 0, 2, 0, 0);
        send_units(1, 1, 0, 0, 0, 0, 0, 0, 0, 2, 0, 0);
        send_units(1, 1, 0, 1, 0, 0, 0, 0, 0, 2, 0, 0);
        send_units(1, 1, 1, 0, -1, 0, 3, 3, 3, 3, 3, 3);
        send_units(1, 1, 0, 2, -2, 0, 0, 0, 0, 4, 4, 0);
        send_units(-1, 2, 1, 1, 0, -1, 0, 0, 0, 0, 4, 2);
        for (int k = 0; k < 12; k++) f[k] = '0;
        send_query(f);
        for (int k = 0; k < 12; k++) f[k] = 32'sh7FFFFFFF;
        send_query(f);
        for (int k = 0; k < 12; k++) f[k] = 32'sh80000000;
        send_query(f);
        for (int k = 0; k < 12; k++) f[k] = k[0] ? 32'sh80000000 : 32'sh7FFFFFFF;
        send_query(f);
        for (int k = 0; k < 12; k++) f[k] = k[1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        send_query(f);
        for (int k = 0; k < 12; k++) f[k] = -1;
        send_query(f);
        for (int k = 0; k < 12; k++) f[k] = (k % 3 == 1) ? 32'sh7FFFFFFF : 1;
        send_query(f);
        send_units(0, 1, 0, 0, -1, 0, 0, 0, 0, 1, 0, 0);

        // Random phases, each under its own tolerance
        tol_plan = '{17'd1, 17'd0, 17'd65536, 17'h0FFFF, 17'd64};
        for (int ph = 0; ph < 5; ph++) begin
            drain_pipe();
            write_tolerance(tol_plan[ph]);
            if (ph == 4) gaps_on = 1'b0;
            for (int n = 0; n < 150; n++) begin
                if (ph == 1 && n == 20) squeeze_req = 1'b1;
                send_random();
            end
            if (ph == 1) begin
                // two queries through the segment ends under the zero tolerance
                send_units(0, 1, 0, 0, -1, 0, 0, 0, 0, 1, 0, 0);
                send_units(1, 1, 0, 0, -1, 0, 0, 0, 0, 1, 0, 0);
            end
        end
        drain_pipe();

        if (mismatches == 0)
            $display("tb_line_segment_intersect_3d_unit passed");
        else
            $display("tb_line_segment_intersect_3d_unit failed");
        $finish;
    end
endmodule
